### rtl/psr_pkg.sv
// Shared types, constants and helpers for the packet segmenter with frame ring.
package psr_pkg;

   // ring of frame slots
   localparam int RING_DEPTH  = 32;
   localparam int MAX_FRAMES  = 32;
   localparam int PTR_W       = $clog2(RING_DEPTH);
   localparam int LIMIT_W     = $clog2(MAX_FRAMES + 1);
   localparam int CNT_W       = (PTR_W > LIMIT_W) ? PTR_W : LIMIT_W;

   // field widths
   localparam int CAP_W       = 10;
   localparam int LEN_W       = 16;
   localparam int SLOT_W      = 5;
   localparam int TAG_W       = 8;
   localparam int IDX_W       = 6;
   localparam int PROD_W      = LIMIT_W + CAP_W;
   localparam int CMP_W       = ((PROD_W > LEN_W) ? PROD_W : LEN_W) + 1;

   // stream payload widths
   localparam int REQ_DATA_W  = 16;
   localparam int REQ_USER_W  = 3;
   localparam int RSP_DATA_W  = 48;
   localparam int RSP_USER_W  = 4;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // capacity register
   localparam int CAP_MIN     = 4;
   localparam int CAP_RESET   = 394;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_FRAME_CAPACITY = '0;

   typedef enum logic [1:0] {
      OP_SEGMENT = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CMD_SEGMENT = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_RELEASE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_FRAME      = 3'd0,
      ST_NO_ROOM    = 3'd1,
      ST_PRIO_BUSY  = 3'd2,
      ST_DEQUEUED   = 3'd3,
      ST_RING_EMPTY = 3'd4,
      ST_RELEASED   = 3'd5
   } status_type;

   typedef struct packed {
      kind_type            kind;
      logic [LEN_W-1:0]    len;
      logic                prio;
   } cmd_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic                prio_frame;
      logic [TAG_W-1:0]    tag;
      logic [IDX_W-1:0]    idx;
      logic [LEN_W-1:0]    offset;
      logic [CAP_W-1:0]    seg_len;
      logic                more_mark;
      logic                end_mark;
      logic                length_field;
      logic                last;
   } rsp_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] to_slot(input logic [PTR_W-1:0] p);
      logic [PTR_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, p};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

### rtl/psr_front.sv
// Input stage: takes request transactions, classifies the operation, feeds the queue.
module psr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [psr_pkg::REQ_DATA_W-1:0] req_tdata,  // [15:0] packet_length
   input  logic [psr_pkg::REQ_USER_W-1:0] req_tuser,  // [1:0] operation, [2] is_priority
   output psr_pkg::cmd_type              cmd,
   output logic                          cmd_valid,
   input  logic                          cmd_ready
);
   import psr_pkg::*;

   cmd_type cmd_ff, cmd_in;
   logic    valid_ff, valid_in;
   logic    take;
   logic    keep;

   assign req_tready = !valid_ff || cmd_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      cmd_in       = cmd_ff;
      cmd_in.len   = req_tdata[LEN_W-1:0];
      cmd_in.prio  = req_tuser[2];
      keep         = 1'b1;
      unique case (op_type'(req_tuser[1:0]))
         OP_SEGMENT: cmd_in.kind = CMD_SEGMENT;
         OP_DEQUEUE: cmd_in.kind = CMD_DEQUEUE;
         OP_RELEASE: cmd_in.kind = CMD_RELEASE;
         default:    keep = 1'b0;  // unused code: consumed, nothing queued
      endcase
      if (!take) begin
         cmd_in = cmd_ff;
      end
      if (take) begin
         valid_in = keep;
      end else if (cmd_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign cmd       = cmd_ff;
   assign cmd_valid = valid_ff;

endmodule

### rtl/psr_queue.sv
// Short command queue between the front and back halves.
module psr_queue (
   input  logic             clock,
   input  logic             reset,
   input  psr_pkg::cmd_type push_cmd,
   input  logic             push_valid,
   output logic             push_ready,
   output psr_pkg::cmd_type pop_cmd,
   output logic             pop_valid,
   input  logic             pop
);
   import psr_pkg::*;

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] wr_ff, wr_in;
   logic [QIDX_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   function automatic logic [QIDX_W-1:0] qnext(input logic [QIDX_W-1:0] p);
      return (p == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_cmd    = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in  = do_push ? qnext(wr_ff) : wr_ff;
      rd_in  = do_pop  ? qnext(rd_ff) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/psr_back.sv
// Execution half: ring pointers, tag counter, priority slot, frame generation.
module psr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [psr_pkg::CAP_W-1:0] cap_eff,
   input  psr_pkg::cmd_type          q_cmd,
   input  logic                      q_valid,
   output logic                      q_pop,
   output psr_pkg::rsp_type          rsp,
   output logic                      rsp_valid,
   input  logic                      rsp_ready
);
   import psr_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MUL   = 5'b00010,
      S_CHECK = 5'b00100,
      S_EMIT  = 5'b01000,
      S_TAIL  = 5'b10000
   } state_type;

   localparam logic [PTR_W:0] DEPTH_V = (PTR_W+1)'(RING_DEPTH);

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic               busy_ff, busy_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               prio_ff, prio_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [LEN_W-1:0]   off_ff, off_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               one_ff, one_in;
   rsp_type            out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic               out_free;
   logic [PTR_W:0]     occ_wide;
   logic [PTR_W-1:0]   room;
   logic [CNT_W-1:0]   room_ext;
   logic [CNT_W-1:0]   limit_ext;
   logic [CMP_W-1:0]   len_c;
   logic [CMP_W-1:0]   prod_c;
   logic               drop;
   logic [LEN_W-1:0]   cap_l;
   logic [LEN_W-1:0]   cap_m1;
   logic [CAP_W-1:0]   seg;
   logic               f_more, f_end, f_lenf, f_fin;

   assign out_free = !out_valid_ff || rsp_ready;

   // free room in the ring, capped at the per-packet frame limit
   always_comb begin
      occ_wide  = {1'b0, tail_ff} + ((tail_ff < head_ff) ? DEPTH_V : '0) - {1'b0, head_ff};
      room      = PTR_W'(RING_DEPTH - 1) - occ_wide[PTR_W-1:0];
      room_ext  = CNT_W'(room);
      limit_ext = (room_ext < CNT_W'(MAX_FRAMES)) ? room_ext : CNT_W'(MAX_FRAMES);
   end

   // drop when the limit is zero or frame count exceeds the limit: L > limit*C, or L == limit*C - 1
   always_comb begin
      len_c  = CMP_W'(len_ff);
      prod_c = CMP_W'(prod_ff);
      drop   = (limit_ff == '0) ? 1'b1 : ((len_c > prod_c) || (len_c == prod_c - 1'b1));
      cap_l  = LEN_W'(cap_ff);
      cap_m1 = cap_l - 1'b1;
   end

   // per-frame split of the remaining bytes
   always_comb begin
      seg    = cap_ff;
      f_more = 1'b1;
      f_end  = 1'b0;
      f_lenf = 1'b0;
      f_fin  = 1'b0;
      if (one_ff) begin
         seg    = rem_ff[CAP_W-1:0];
         f_more = 1'b0;
         f_end  = 1'b1;
         f_lenf = (rem_ff != cap_l);
         f_fin  = 1'b1;
      end else if (rem_ff < cap_m1) begin
         seg    = rem_ff[CAP_W-1:0];
         f_end  = 1'b1;
         f_lenf = 1'b1;
         f_fin  = 1'b1;
      end else if (rem_ff == cap_m1) begin
         // one byte short: split so the length field fits
         seg    = cap_ff - CAP_W'(2);
         f_lenf = 1'b1;
      end else if (rem_ff == cap_l) begin
         f_end  = 1'b1;
         f_fin  = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      tag_in       = tag_ff;
      busy_in      = busy_ff;
      len_in       = len_ff;
      prio_in      = prio_ff;
      cap_in       = cap_ff;
      limit_in     = limit_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      off_in       = off_ff;
      idx_in       = idx_ff;
      one_in       = one_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      q_pop        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               unique case (q_cmd.kind)
                  CMD_SEGMENT: begin
                     tag_in   = tag_ff + 1'b1;
                     len_in   = q_cmd.len;
                     prio_in  = q_cmd.prio;
                     cap_in   = cap_eff;
                     limit_in = limit_ext[LIMIT_W-1:0];
                     state_in = S_MUL;
                  end
                  CMD_DEQUEUE: begin
                     out_in       = '0;
                     out_in.last  = 1'b1;
                     out_valid_in = 1'b1;
                     if (head_ff == tail_ff) begin
                        out_in.status = ST_RING_EMPTY;
                     end else begin
                        out_in.status = ST_DEQUEUED;
                        out_in.slot   = to_slot(head_ff);
                        head_in       = ptr_next(head_ff);
                     end
                  end
                  CMD_RELEASE: begin
                     busy_in       = 1'b0;
                     out_in        = '0;
                     out_in.status = ST_RELEASED;
                     out_in.last   = 1'b1;
                     out_valid_in  = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(limit_ff) * PROD_W'(cap_ff);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (out_free) begin
               out_in      = '0;
               out_in.tag  = tag_ff;
               out_in.last = 1'b1;
               if (len_ff == '0) begin
                  state_in = S_IDLE;
               end else if (drop) begin
                  out_in.status = ST_NO_ROOM;
                  out_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else if (prio_ff && busy_ff) begin
                  out_in.status = ST_PRIO_BUSY;
                  out_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  rem_in   = len_ff;
                  off_in   = '0;
                  idx_in   = '0;
                  one_in   = (len_ff <= cap_l) && (len_ff != cap_m1);
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_in.status       = ST_FRAME;
               out_in.slot         = prio_ff ? '0 : to_slot(tail_ff);
               out_in.prio_frame   = prio_ff;
               out_in.tag          = tag_ff;
               out_in.idx          = idx_ff;
               out_in.offset       = off_ff;
               out_in.seg_len      = seg;
               out_in.more_mark    = f_more;
               out_in.end_mark     = f_end;
               out_in.length_field = f_lenf;
               out_in.last         = f_fin;
               out_valid_in        = 1'b1;
               rem_in              = rem_ff - LEN_W'(seg);
               off_in              = off_ff + LEN_W'(seg);
               idx_in              = idx_ff + 1'b1;
               if (prio_ff) begin
                  busy_in  = 1'b1;
                  state_in = f_fin ? S_IDLE : S_TAIL;
               end else begin
                  tail_in  = ptr_next(tail_ff);
                  state_in = f_fin ? S_IDLE : S_EMIT;
               end
            end
         end
         S_TAIL: begin
            // rest of a multi-frame priority packet is dropped
            if (out_free) begin
               out_in        = '0;
               out_in.status = ST_PRIO_BUSY;
               out_in.tag    = tag_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      prio_ff  <= prio_in;
      cap_ff   <= cap_in;
      limit_ff <= limit_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      off_ff   <= off_in;
      idx_ff   <= idx_in;
      one_ff   <= one_in;
      out_ff   <= out_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         tag_ff       <= '0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         tag_ff       <= tag_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp       = out_ff;
   assign rsp_valid = out_valid_ff;

endmodule

### rtl/packet_segmenter_with_frame_ring_unit.sv
// Top level: packet segmenter with frame ring, register port and stream channels.
// Ordering: dequeue and release results are registered by the back unit after the front
//   register and the queue; a segment request gives its first result after setup.
// Throughput: frames of one packet leave at one per cycle while the response channel is ready
//   (back unit loop); a packet passes setup (tag/room, multiply, check) before its frames.
// Reset: synchronous, active high; clears ring pointers, tag, priority flag,
//   queue and output stage, and sets frame capacity to 394.
module packet_segmenter_with_frame_ring_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [psr_pkg::REQ_DATA_W-1:0]    req_tdata,  // [15:0] packet_length
   input  logic [psr_pkg::REQ_USER_W-1:0]    req_tuser,  // [1:0] operation, [2] is_priority
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [4:0] slot, [12:5] packet_tag, [18:13] segment_index, [34:19] segment_offset,
   // [44:35] segment_length, [45] more_mark, [46] end_mark, [47] length_field
   output logic [psr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [psr_pkg::RSP_USER_W-1:0]    rsp_tuser,  // [2:0] status, [3] priority_frame
   output logic                              rsp_tlast,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [psr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [psr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [psr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import psr_pkg::*;

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CAP_W-1:0] cap_eff;
   logic             csr_hit;
   logic             csr_wr;

   cmd_type          front_cmd;
   logic             front_valid;
   logic             queue_ready;
   cmd_type          q_cmd;
   logic             q_valid;
   logic             q_pop;
   rsp_type          rsp;

   // register file: single capacity register at offset 0
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_FRAME_CAPACITY);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(cap_ff) : '0;
   assign cap_in     = (csr_wr && csr_hit) ? csr_pwdata[CAP_W-1:0] : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_W'(CAP_RESET);
      end else begin
         cap_ff <= cap_in;
      end
   end

   // capacities below the minimum act as the minimum
   assign cap_eff = (cap_ff < CAP_W'(CAP_MIN)) ? CAP_W'(CAP_MIN) : cap_ff;

   // front: accept and classify each transaction
   psr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (front_cmd),
      .cmd_valid  (front_valid),
      .cmd_ready  (queue_ready)
   );

   // decoupling queue so front and back stall independently
   psr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (front_cmd),
      .push_valid (front_valid),
      .push_ready (queue_ready),
      .pop_cmd    (q_cmd),
      .pop_valid  (q_valid),
      .pop        (q_pop)
   );

   // back: ring state, drop decisions, frame walk, output register
   psr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cap_eff   (cap_eff),
      .q_cmd     (q_cmd),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .rsp       (rsp),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {rsp.length_field, rsp.end_mark, rsp.more_mark, rsp.seg_len,
                       rsp.offset, rsp.idx, rsp.tag, rsp.slot};
   assign rsp_tuser = {rsp.prio_frame, rsp.status};
   assign rsp_tlast = rsp.last;

   // priority frames always report slot 0
   a_prio_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.prio_frame |-> rsp.status == ST_FRAME && rsp.slot == '0)
      else $error("priority frame with nonzero slot");

   // non-frame results are always the final result of their transaction
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.status != ST_FRAME |-> rsp.last)
      else $error("status result without last");

   // the final frame of a packet always carries the end mark and some payload
   a_final_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.status == ST_FRAME && rsp.last |-> rsp.end_mark && rsp.seg_len != '0)
      else $error("final frame without end mark or payload");

endmodule
